@@ rtl/core/mvm_pkg.sv @@
// Shared types and constants for the matrix-vector multiply block.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package mvm_pkg;

    // store geometry
    localparam int MAX_DIM = 16;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int ADDR_W  = 2 * IDX_W;

    // field widths fixed by the interface
    localparam int PORT_IDX_W = 4;
    localparam int DATA_W     = 32;
    localparam int DIM_W      = 5;
    localparam int CFG_IDX_W  = 1;

    // arithmetic widths: full product, exact sum over MAX_DIM terms
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + CNT_W + 1;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD_MATRIX = 2'd0,
        CMD_LOAD_VECTOR = 2'd1,
        CMD_COMPUTE     = 2'd2
    } mvm_cmd_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_DIM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_DIM = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } mvm_state_t;

    // marks that travel with each store read
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mvm_tag_t;

    // row result status from the mac unit
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] value;
    } mvm_mac_stat_t;

endpackage

@@ rtl/core/matrix_vector_multiply.sv @@
// Matrix-vector multiply, signed Q16.16.
// Input channel (in_valid / in_stall) carries one command per transfer:
// load a matrix entry, load a vector element, or compute. Loads write the
// internal stores and never stall the input, so they stream back to back;
// a load with an index past the store size is dropped, code 3 is ignored.
// A compute emits one result per active row (n = lesser of the two
// dimension registers, capped at the store size) on the output channel
// (out_valid / out_stall), rows in order, last set on the final one.
// During a compute, one shared multiplier handles one product per cycle
// (n store reads per row), and each row then passes through multiply,
// accumulate and hand-over of its result. in_stall is high for the whole
// run. Results pass through an output register, so a stalled receiver only
// holds the run at its next row hand-over; the next command is taken while
// the final result still waits. Reset clears control and sets both
// dimensions to the store size; store contents are undefined until
// written. The user must write configuration (cfg_we, cfg_index,
// cfg_data) only while idle; the block does not check.
// Depends on mvm_pkg, mvm_store, mvm_mac, mvm_seq.
`timescale 1ns / 1ps

module matrix_vector_multiply (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mvm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mvm_pkg::DIM_W-1:0]              cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             cmd,
    input  logic [mvm_pkg::PORT_IDX_W-1:0]         row_index,
    input  logic [mvm_pkg::PORT_IDX_W-1:0]         col_index,
    input  logic signed [mvm_pkg::DATA_W-1:0]      element_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [mvm_pkg::PORT_IDX_W-1:0]         result_row,
    output logic signed [mvm_pkg::DATA_W-1:0]      result_value,
    output logic                                   last
);

    localparam int CNT_W = mvm_pkg::CNT_W;

    logic [mvm_pkg::DIM_W-1:0]   matrix_dim_reg;
    logic [mvm_pkg::DIM_W-1:0]   vector_dim_reg;
    logic [CNT_W-1:0]            md_eff;
    logic [CNT_W-1:0]            vd_eff;
    logic [CNT_W-1:0]            n_active;
    logic                        in_xfer;
    logic                        in_range;
    logic                        mat_we;
    logic                        vec_we;
    logic                        start;
    logic                        busy;
    logic                        rd_en;
    logic [mvm_pkg::IDX_W-1:0]   rd_row;
    logic [mvm_pkg::IDX_W-1:0]   rd_col;
    logic [mvm_pkg::DATA_W-1:0]  mat_q;
    logic [mvm_pkg::DATA_W-1:0]  vec_q;
    logic [mvm_pkg::DATA_W-1:0]  out_value;
    logic                        take;
    mvm_pkg::mvm_tag_t           tag;
    mvm_pkg::mvm_mac_stat_t      stat;

    // dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_dim_reg <= mvm_pkg::DIM_W'(16);
            vector_dim_reg <= mvm_pkg::DIM_W'(16);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mvm_pkg::CFG_MATRIX_DIM: matrix_dim_reg <= cfg_data;
                mvm_pkg::CFG_VECTOR_DIM: vector_dim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // active size: both dimensions capped at the store size, then the lesser
    always_comb
    begin
        md_eff = (int'(matrix_dim_reg) > mvm_pkg::MAX_DIM) ?
                 CNT_W'(mvm_pkg::MAX_DIM) : CNT_W'(matrix_dim_reg);
        vd_eff = (int'(vector_dim_reg) > mvm_pkg::MAX_DIM) ?
                 CNT_W'(mvm_pkg::MAX_DIM) : CNT_W'(vector_dim_reg);
        n_active = (md_eff < vd_eff) ? md_eff : vd_eff;
    end

    // command decode on input transfer
    assign in_stall = busy;
    assign in_xfer  = in_valid && !in_stall;
    assign in_range = (int'(row_index) < mvm_pkg::MAX_DIM)
                   && (int'(col_index) < mvm_pkg::MAX_DIM);
    assign mat_we   = in_xfer && (cmd == mvm_pkg::CMD_LOAD_MATRIX) && in_range;
    assign vec_we   = in_xfer && (cmd == mvm_pkg::CMD_LOAD_VECTOR)
                   && (int'(col_index) < mvm_pkg::MAX_DIM);
    assign start    = in_xfer && (cmd == mvm_pkg::CMD_COMPUTE);

    mvm_store u_store (
        .clk     (clk),
        .mat_we  (mat_we),
        .vec_we  (vec_we),
        .wr_row  (mvm_pkg::IDX_W'(row_index)),
        .wr_col  (mvm_pkg::IDX_W'(col_index)),
        .wr_data (element_value),
        .rd_en   (rd_en),
        .rd_row  (rd_row),
        .rd_col  (rd_col),
        .mat_q   (mat_q),
        .vec_q   (vec_q)
    );

    mvm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag),
        .mat_q (mat_q),
        .vec_q (vec_q),
        .take  (take),
        .stat  (stat)
    );

    mvm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .n_active  (n_active),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_row    (rd_row),
        .rd_col    (rd_col),
        .tag       (tag),
        .stat      (stat),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (result_row),
        .out_value (out_value),
        .out_last  (last)
    );

    assign result_value = out_value;

endmodule

@@ rtl/core/mvm_store.sv @@
// Matrix and vector stores with registered read ports.
// Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_store (
    input  logic                          clk,
    input  logic                          mat_we,
    input  logic                          vec_we,
    input  logic [mvm_pkg::IDX_W-1:0]     wr_row,
    input  logic [mvm_pkg::IDX_W-1:0]     wr_col,
    input  logic [mvm_pkg::DATA_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [mvm_pkg::IDX_W-1:0]     rd_row,
    input  logic [mvm_pkg::IDX_W-1:0]     rd_col,
    output logic [mvm_pkg::DATA_W-1:0]    mat_q,
    output logic [mvm_pkg::DATA_W-1:0]    vec_q
);

    localparam int MAT_DEPTH = 1 << mvm_pkg::ADDR_W;
    localparam int VEC_DEPTH = 1 << mvm_pkg::IDX_W;

    logic [mvm_pkg::DATA_W-1:0] mat_mem [MAT_DEPTH];
    logic [mvm_pkg::DATA_W-1:0] vec_mem [VEC_DEPTH];
    logic [mvm_pkg::DATA_W-1:0] mat_q_reg;
    logic [mvm_pkg::DATA_W-1:0] vec_q_reg;

    // matrix memory, row-major
    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[{wr_row, wr_col}] <= wr_data;
        end
        if (rd_en)
        begin
            mat_q_reg <= mat_mem[{rd_row, rd_col}];
        end
    end

    // vector memory
    always_ff @(posedge clk)
    begin
        if (vec_we)
        begin
            vec_mem[wr_col] <= wr_data;
        end
        if (rd_en)
        begin
            vec_q_reg <= vec_mem[rd_col];
        end
    end

    assign mat_q = mat_q_reg;
    assign vec_q = vec_q_reg;

endmodule

@@ rtl/core/mvm_mac.sv @@
// Shared multiply-accumulate unit: one product per cycle, exact sum,
// then floor shift by the fraction width and saturation. Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mvm_pkg::mvm_tag_t             tag,
    input  logic [mvm_pkg::DATA_W-1:0]    mat_q,
    input  logic [mvm_pkg::DATA_W-1:0]    vec_q,
    input  logic                          take,
    output mvm_pkg::mvm_mac_stat_t        stat
);

    localparam int ACC_W  = mvm_pkg::ACC_W;
    localparam int DATA_W = mvm_pkg::DATA_W;

    mvm_pkg::mvm_tag_t                   tag_d1_reg;
    mvm_pkg::mvm_tag_t                   tag_d2_reg;
    logic signed [mvm_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mvm_pkg::PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [ACC_W-1:0]             acc_next;
    logic                                done_reg;
    logic                                done_next;
    logic signed [DATA_W-1:0]            op_a;
    logic signed [DATA_W-1:0]            op_b;
    logic signed [ACC_W-1:0]             shifted;
    logic [ACC_W-DATA_W:0]               top_bits;
    logic [DATA_W-1:0]                   sat_value;

    // tag pipeline, aligned with read data and then with the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d1_reg <= '0;
            tag_d2_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            tag_d1_reg <= tag;
            tag_d2_reg <= tag_d1_reg;
            done_reg   <= done_next;
        end
    end

    // full-width signed product
    assign op_a      = mat_q;
    assign op_b      = vec_q;
    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        if (tag_d1_reg.valid)
        begin
            prod_reg <= prod_next;
        end
        if (tag_d2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // accumulate, restarting on the first term of a row
    always_comb
    begin
        if (tag_d2_reg.first)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    // row done flag, held until the sequencer takes the result
    always_comb
    begin
        done_next = done_reg;
        if (tag_d2_reg.valid && tag_d2_reg.last)
        begin
            done_next = 1'b1;
        end
        else if (take)
        begin
            done_next = 1'b0;
        end
    end

    // floor shift and saturation to the result width
    assign shifted  = acc_reg >>> mvm_pkg::FRAC_W;
    assign top_bits = shifted[ACC_W-1:DATA_W-1];

    always_comb
    begin
        if ((&top_bits) || !(|top_bits))
        begin
            sat_value = shifted[DATA_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = sat_value;

endmodule

@@ rtl/core/mvm_seq.sv @@
// Sequencer: walks rows and columns of a compute run, feeds the store and
// mac unit, and holds the output register. Depends on mvm_pkg.
`timescale 1ns / 1ps

module mvm_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mvm_pkg::CNT_W-1:0]         n_active,
    output logic                              busy,
    output logic                              rd_en,
    output logic [mvm_pkg::IDX_W-1:0]         rd_row,
    output logic [mvm_pkg::IDX_W-1:0]         rd_col,
    output mvm_pkg::mvm_tag_t                 tag,
    input  mvm_pkg::mvm_mac_stat_t            stat,
    output logic                              take,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mvm_pkg::PORT_IDX_W-1:0]    out_row,
    output logic [mvm_pkg::DATA_W-1:0]        out_value,
    output logic                              out_last
);

    localparam int CNT_W = mvm_pkg::CNT_W;

    mvm_pkg::mvm_state_t          state_reg;
    mvm_pkg::mvm_state_t          state_next;
    logic [CNT_W-1:0]             row_reg;
    logic [CNT_W-1:0]             row_next;
    logic [CNT_W-1:0]             k_reg;
    logic [CNT_W-1:0]             k_next;
    logic [CNT_W-1:0]             n_reg;
    logic [CNT_W-1:0]             n_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [mvm_pkg::PORT_IDX_W-1:0] out_row_reg;
    logic [mvm_pkg::DATA_W-1:0]   out_value_reg;
    logic                         out_last_reg;
    logic                         load_out;
    logic                         row_is_last;
    logic                         k_is_last;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mvm_pkg::ST_IDLE;
            row_reg       <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_row_reg   <= mvm_pkg::PORT_IDX_W'(row_reg);
            out_value_reg <= stat.value;
            out_last_reg  <= row_is_last;
        end
    end

    assign row_is_last = (row_reg == n_reg - CNT_W'(1));
    assign k_is_last   = (k_reg == n_reg - CNT_W'(1));

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        rd_en      = 1'b0;
        tag        = '0;
        take       = 1'b0;
        load_out   = 1'b0;
        busy       = 1'b1;

        unique case (state_reg)
            mvm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start && (n_active != '0))
                begin
                    n_next     = n_active;
                    row_next   = '0;
                    k_next     = '0;
                    state_next = mvm_pkg::ST_ISSUE;
                end
            end
            mvm_pkg::ST_ISSUE:
            begin
                rd_en     = 1'b1;
                tag.valid = 1'b1;
                tag.first = (k_reg == '0);
                tag.last  = k_is_last;
                if (k_is_last)
                begin
                    k_next     = '0;
                    state_next = mvm_pkg::ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            mvm_pkg::ST_WAIT:
            begin
                if (stat.done && (!out_valid_reg || !out_stall))
                begin
                    take     = 1'b1;
                    load_out = 1'b1;
                    if (row_is_last)
                    begin
                        state_next = mvm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + CNT_W'(1);
                        state_next = mvm_pkg::ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = mvm_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rd_row    = row_reg[mvm_pkg::IDX_W-1:0];
    assign rd_col    = k_reg[mvm_pkg::IDX_W-1:0];
    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

@@ rtl/core/mvm_checker.sv @@
// Port-level checks for the matrix-vector multiply top level, with the bind
// that attaches them. Depends on mvm_pkg and matrix_vector_multiply.
`timescale 1ns / 1ps

module mvm_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic [1:0]                            cmd,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [mvm_pkg::PORT_IDX_W-1:0]        result_row,
    input logic [mvm_pkg::DATA_W-1:0]            result_value,
    input logic                                  last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_row)
            && $stable(result_value) && $stable(last))
    else $error("stalled result changed");

    // a result that is not the last one means a run is still going
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
    else $error("input open while a run is unfinished");

    // loads never start a run
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (cmd == mvm_pkg::CMD_LOAD_MATRIX
            || cmd == mvm_pkg::CMD_LOAD_VECTOR) |=> !in_stall)
    else $error("load transfer blocked the input");

    // after a non-final result transfers, the run goes on or its final result is up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> in_stall || (out_valid && last))
    else $error("run ended without a final result");

endmodule

bind matrix_vector_multiply mvm_checker u_mvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_row   (result_row),
    .result_value (result_value),
    .last         (last)
);
